[sv/ppr_pkg.sv]
// shared widths, codes and stage types for the point pair reflection block
package ppr_pkg;

  localparam int COORD_W        = 32;
  localparam int CFG_W          = 31;
  localparam int CFG_IDX_W      = 2;
  localparam int UNIT_FRAC_BITS = 30;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int SQ_W           = 2 * DIFF_W;
  localparam int L2_W           = SQ_W + 1;
  localparam int RAD_W          = L2_W + (L2_W % 2);
  localparam int SQRT_STEPS     = RAD_W / 2;
  localparam int ROOT_W         = SQRT_STEPS;
  localparam int SQ_REM_W       = ROOT_W + 2;
  localparam int NUM_W          = DIFF_W + UNIT_FRAC_BITS;
  localparam int DIV_STEPS      = 32;
  localparam int DIV_REM_W      = ROOT_W;
  localparam int Q_W            = UNIT_FRAC_BITS + 1;
  localparam int PROD_W         = 2 * Q_W;
  localparam int RND_SHIFT      = UNIT_FRAC_BITS - 1;
  localparam int RND_W          = PROD_W + 1 - RND_SHIFT;
  localparam int MM_W           = 2 * CFG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LENGTH   = 2'd0,
    CFG_SIGN_EPSILON = 2'd1
  } ppr_cfg_e;

  // what every stage up to the sign choice carries along
  typedef struct packed {
    logic                           vld;
    logic                           rej;
    logic [2:0]                     neg;
    logic [2:0][DIFF_W-1:0]         mag;
    logic [2:0][COORD_W-1:0]        ctr;
  } ppr_item_t;

  typedef struct packed {
    ppr_item_t                      it;
    logic [RAD_W-1:0]               rad;
    logic [SQ_REM_W-1:0]            rem;
    logic [ROOT_W-1:0]              root;
  } ppr_sqrt_t;

  typedef struct packed {
    ppr_item_t                      it;
    logic [ROOT_W-1:0]              len;
    logic [2:0][DIV_REM_W-1:0]      rem;
    logic [2:0][DIV_STEPS-1:0]      nb;
  } ppr_div_t;

  typedef struct packed {
    logic                           vld;
    logic                           rej;
    logic [2:0][2:0][PROD_W-1:0]    pmag;
    logic [2:0][2:0]                pneg;
    logic [2:0][COORD_W-1:0]        nrm;
    logic [2:0][COORD_W-1:0]        ctr;
  } ppr_prod_t;

endpackage

[sv/ppr_pair_if.sv]
// channel interfaces: point pair words in, matrix row words out
interface ppr_pair_if import ppr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_y;
  logic signed [COORD_W-1:0] first_z;
  logic signed [COORD_W-1:0] second_x;
  logic signed [COORD_W-1:0] second_y;
  logic signed [COORD_W-1:0] second_z;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                output ready);
endinterface

interface ppr_row_if import ppr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                row_index;
  logic                      is_last;
  logic                      valid_res;
  logic signed [COORD_W-1:0] mat_col0;
  logic signed [COORD_W-1:0] mat_col1;
  logic signed [COORD_W-1:0] mat_col2;
  logic signed [COORD_W-1:0] normal_part;
  logic signed [COORD_W-1:0] center_part;

  modport source (output valid, row_index, is_last, valid_res, mat_col0, mat_col1,
                  mat_col2, normal_part, center_part, input ready);
  modport sink (input valid, row_index, is_last, valid_res, mat_col0, mat_col1,
                mat_col2, normal_part, center_part, output ready);
endinterface

[sv/ppr_sqrt_step.sv]
// one registered digit step of the integer square root
module ppr_sqrt_step import ppr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  ppr_sqrt_t st_i,
  output ppr_sqrt_t st_o
);
  logic [SQ_REM_W+1:0] rem_sh;
  logic [SQ_REM_W+1:0] trial;
  logic [SQ_REM_W+1:0] diff;
  logic                ge;
  ppr_sqrt_t           st_d;
  ppr_sqrt_t           st_q;

  always_comb begin
    rem_sh = {st_i.rem, st_i.rad[RAD_W-1 -: 2]};
    trial  = {{(SQ_REM_W-ROOT_W){1'b0}}, st_i.root, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
    st_d      = st_i;
    st_d.rad  = {st_i.rad[RAD_W-3:0], 2'b00};
    st_d.rem  = ge ? diff[SQ_REM_W-1:0] : rem_sh[SQ_REM_W-1:0];
    st_d.root = {st_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;
endmodule

[sv/ppr_div_step.sv]
// one registered restoring step of the three normal divisions
module ppr_div_step import ppr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  ppr_div_t st_i,
  output ppr_div_t st_o
);
  ppr_div_t st_d;
  ppr_div_t st_q;
  logic [2:0][DIV_REM_W:0] t;
  logic [2:0][DIV_REM_W:0] diff;
  logic [2:0]              ge;

  always_comb begin
    st_d = st_i;
    for (int i = 0; i < 3; i++) begin
      t[i]    = {st_i.rem[i], st_i.nb[i][DIV_STEPS-1]};
      diff[i] = t[i] - {1'b0, st_i.len};
      ge[i]   = (t[i] >= {1'b0, st_i.len});
      st_d.rem[i] = ge[i] ? diff[i][DIV_REM_W-1:0] : t[i][DIV_REM_W-1:0];
      st_d.nb[i]  = {st_i.nb[i][DIV_STEPS-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;
endmodule

[sv/ppr_row_out.sv]
// final rounding of the matrix and the output register that sends three row words, or one for a rejected pair
module ppr_row_out import ppr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ppr_prod_t prod_i,
  output logic      take_o,
  ppr_row_if.source row_out
);
  logic [2:0][2:0][COORD_W-1:0] h_d;
  logic [2:0][2:0][COORD_W-1:0] h_q;
  logic [2:0][COORD_W-1:0]      nrm_q;
  logic [2:0][COORD_W-1:0]      ctr_q;
  logic                         hold_q;
  logic                         rej_q;
  logic [1:0]                   row_q;
  logic [1:0]                   row_d;
  logic                         last;
  logic [PROD_W:0]              rsum;
  logic [RND_W-1:0]             rnd;
  logic [RND_W-1:0]             srnd;
  logic [RND_W-1:0]             ent;

  // h = delta * 2^u - round(2 * ni * nj / 2^u), half away from zero
  always_comb begin
    h_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rsum = {1'b0, prod_i.pmag[i][j]} + (PROD_W+1)'(1) * (1 << (RND_SHIFT-1));
        rnd  = RND_W'(rsum >> RND_SHIFT);
        srnd = prod_i.pneg[i][j] ? (~rnd + RND_W'(1)) : rnd;
        ent  = (i == j) ? (RND_W'(1) << UNIT_FRAC_BITS) - srnd : RND_W'(0) - srnd;
        h_d[i][j] = ent[COORD_W-1:0];
      end
    end
  end

  assign last   = rej_q || (row_q == 2'd2);
  assign take_o = !hold_q || (row_out.ready && last);
  assign row_d  = row_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      row_q  <= 2'd0;
    end else if (take_o) begin
      hold_q <= prod_i.vld;
      row_q  <= 2'd0;
    end else if (row_out.ready) begin
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      rej_q <= prod_i.rej;
      if (prod_i.rej) begin
        h_q   <= '0;
        nrm_q <= '0;
        ctr_q <= '0;
      end else begin
        h_q   <= h_d;
        nrm_q <= prod_i.nrm;
        ctr_q <= prod_i.ctr;
      end
    end
  end

  always_comb begin
    row_out.valid       = hold_q;
    row_out.row_index   = row_q;
    row_out.is_last     = last;
    row_out.valid_res   = !rej_q;
    row_out.mat_col0    = h_q[0][0];
    row_out.mat_col1    = h_q[0][1];
    row_out.mat_col2    = h_q[0][2];
    row_out.normal_part = nrm_q[0];
    row_out.center_part = ctr_q[0];
    case (row_q)
      2'd1: begin
        row_out.mat_col0    = h_q[1][0];
        row_out.mat_col1    = h_q[1][1];
        row_out.mat_col2    = h_q[1][2];
        row_out.normal_part = nrm_q[1];
        row_out.center_part = ctr_q[1];
      end
      2'd2: begin
        row_out.mat_col0    = h_q[2][0];
        row_out.mat_col1    = h_q[2][1];
        row_out.mat_col2    = h_q[2][2];
        row_out.normal_part = nrm_q[2];
        row_out.center_part = ctr_q[2];
      end
      default: ;
    endcase
  end
endmodule

[sv/point_pair_reflection_matrix.sv]
// top level: mirror plane, midpoint and householder matrix of a point pair
// A pair word goes through a pipeline of 72 register stages: difference and
// midpoint, squares, squared length, a 34-stage square root (one result bit per
// stage), a 32-stage division for the three normal components, sign choice, the
// nine products, then an output register. A valid pair leaves as three row words
// (rows 0..2), a pair that is too close as one rejected word. The output register
// sends one word per cycle while row_out.ready is high; the pipeline moves
// whenever the output register is free or sends its last word, and stands
// still while it holds the earlier rows of a pair. Configuration
// writes apply to pairs accepted at the write edge or later; write only while no
// pair is in flight.
module point_pair_reflection_matrix import ppr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  ppr_pair_if.sink             pair_in,
  ppr_row_if.source            row_out
);
  logic [CFG_W-1:0] min_len_q;
  logic [CFG_W-1:0] eps_q;
  logic [MM_W-1:0]  mm_q;
  logic             en;

  ppr_item_t                s1_d, s1_q, s2_q;
  logic [2:0][SQ_W-1:0]     sq_q;
  ppr_item_t                s3_d, s3_q;
  logic [L2_W-1:0]          l2_q;
  logic [L2_W-1:0]          l2_d;
  ppr_sqrt_t                sq_pipe [SQRT_STEPS+1];
  ppr_div_t                 dv_pipe [DIV_STEPS+1];
  logic [2:0][NUM_W-1:0]    num;
  ppr_item_t                sg_q;
  logic [2:0][Q_W-1:0]      q_q;
  logic [2:0][COORD_W-1:0]  n_q;
  logic [2:0]               qneg_q;
  logic                     flip;
  ppr_prod_t                pr_d, pr_q;
  logic [2:0][COORD_W-1:0]  fa, fb;
  logic [2:0][DIFF_W-1:0]   dif, sum;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= CFG_W'(1);
      eps_q     <= CFG_W'(128);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_LENGTH:   min_len_q <= cfg_data_i;
        CFG_SIGN_EPSILON: eps_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mm_q <= min_len_q * min_len_q;
  end

  assign pair_in.ready = en;

  // difference, magnitude and midpoint
  always_comb begin
    fa = {pair_in.first_z, pair_in.first_y, pair_in.first_x};
    fb = {pair_in.second_z, pair_in.second_y, pair_in.second_x};
    s1_d     = '0;
    s1_d.vld = pair_in.valid;
    for (int i = 0; i < 3; i++) begin
      dif[i] = {fb[i][COORD_W-1], fb[i]} - {fa[i][COORD_W-1], fa[i]};
      sum[i] = {fb[i][COORD_W-1], fb[i]} + {fa[i][COORD_W-1], fa[i]};
      s1_d.neg[i] = dif[i][DIFF_W-1];
      s1_d.mag[i] = dif[i][DIFF_W-1] ? (~dif[i] + DIFF_W'(1)) : dif[i];
      s1_d.ctr[i] = sum[i][DIFF_W-1:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (en) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      s3_q <= s3_d;
    end
  end

  always_comb begin
    l2_d     = L2_W'(sq_q[0]) + L2_W'(sq_q[1]) + L2_W'(sq_q[2]);
    s3_d     = s2_q;
    s3_d.rej = (l2_d < L2_W'(mm_q)) || (l2_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= s1_q.mag[i] * s1_q.mag[i];
      end
      l2_q <= l2_d;
    end
  end

  // square root of the squared length
  always_comb begin
    sq_pipe[0]      = '0;
    sq_pipe[0].it   = s3_q;
    sq_pipe[0].rad  = RAD_W'(l2_q);
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    ppr_sqrt_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .st_i   (sq_pipe[k]),
      .st_o   (sq_pipe[k+1])
    );
  end

  // (|d| << u) + len / 2, divided by len
  always_comb begin
    dv_pipe[0]     = '0;
    dv_pipe[0].it  = sq_pipe[SQRT_STEPS].it;
    dv_pipe[0].len = sq_pipe[SQRT_STEPS].root;
    for (int i = 0; i < 3; i++) begin
      num[i] = {sq_pipe[SQRT_STEPS].it.mag[i], {UNIT_FRAC_BITS{1'b0}}}
             + NUM_W'(sq_pipe[SQRT_STEPS].root >> 1);
      dv_pipe[0].rem[i] = DIV_REM_W'(num[i][NUM_W-1:DIV_STEPS]);
      dv_pipe[0].nb[i]  = num[i][DIV_STEPS-1:0];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    ppr_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .st_i   (dv_pipe[k]),
      .st_o   (dv_pipe[k+1])
    );
  end

  // sign choice: first component above epsilon decides, else z
  always_comb begin
    if (dv_pipe[DIV_STEPS].nb[0][Q_W-1:0] > eps_q) begin
      flip = dv_pipe[DIV_STEPS].it.neg[0];
    end else if (dv_pipe[DIV_STEPS].nb[1][Q_W-1:0] > eps_q) begin
      flip = dv_pipe[DIV_STEPS].it.neg[1];
    end else begin
      flip = dv_pipe[DIV_STEPS].it.neg[2] && (dv_pipe[DIV_STEPS].nb[2][Q_W-1:0] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sg_q <= '0;
    end else if (en) begin
      sg_q <= dv_pipe[DIV_STEPS].it;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q_q[i]    <= dv_pipe[DIV_STEPS].nb[i][Q_W-1:0];
        qneg_q[i] <= dv_pipe[DIV_STEPS].it.neg[i];
        n_q[i]    <= (dv_pipe[DIV_STEPS].it.neg[i] ^ flip)
                   ? (COORD_W'(0) - COORD_W'(dv_pipe[DIV_STEPS].nb[i][Q_W-1:0]))
                   : COORD_W'(dv_pipe[DIV_STEPS].nb[i][Q_W-1:0]);
      end
    end
  end

  // products of the normal magnitudes; the common sign flip cancels in ni * nj
  always_comb begin
    pr_d     = '0;
    pr_d.vld = sg_q.vld;
    pr_d.rej = sg_q.rej;
    pr_d.nrm = n_q;
    pr_d.ctr = sg_q.ctr;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pr_d.pmag[i][j] = q_q[i] * q_q[j];
        pr_d.pneg[i][j] = qneg_q[i] ^ qneg_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_q <= '0;
    end else if (en) begin
      pr_q <= pr_d;
    end
  end

  ppr_row_out u_row_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .prod_i  (pr_q),
    .take_o  (en),
    .row_out (row_out)
  );
endmodule

[verif/tb.sv]
// testbench for the point pair reflection block: directed and random pairs against a predictor
module tb;
  import ppr_pkg::*;

  localparam int UF = UNIT_FRAC_BITS;
  localparam int LATENCY = 120;

  typedef struct {
    logic [1:0]  row_index;
    logic        is_last;
    logic        valid_res;
    logic [31:0] col0;
    logic [31:0] col1;
    logic [31:0] col2;
    logic [31:0] normal;
    logic [31:0] center;
  } row_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  ppr_pair_if pair_in ();
  ppr_row_if row_out ();

  point_pair_reflection_matrix u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pair_in   (pair_in),
    .row_out   (row_out)
  );

  row_word_t expected_rows[$];
  logic [30:0] min_length_q = 31'd1;
  logic [30:0] sign_eps_q = 31'd128;
  int n_errors = 0;
  int n_pairs = 0;
  int n_rows = 0;
  int n_rejects = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  initial forever #1 clk_i = ~clk_i;

  initial begin
    pair_in.valid = 1'b0;
    pair_in.first_x = '0;
    pair_in.first_y = '0;
    pair_in.first_z = '0;
    pair_in.second_x = '0;
    pair_in.second_y = '0;
    pair_in.second_z = '0;
    row_out.ready = 1'b0;
  end

  function automatic logic [67:0] root_of(logic [67:0] v);
    logic [67:0] r;
    logic [67:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (68'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] twice_round(logic signed [63:0] a,
                                                     logic signed [63:0] b);
    logic signed [63:0] p;
    logic [63:0] m;
    logic [63:0] r;
    p = a * b;
    m = (p < 0) ? -p : p;
    r = (m + (64'd1 << (UF - 2))) >> (UF - 1);
    return (p < 0) ? -$signed(r) : $signed(r);
  endfunction

  // expected row words of one pair
  task automatic predict_reflection(logic signed [31:0] p[6]);
    logic signed [63:0] d[3];
    logic signed [63:0] nv[3];
    logic signed [63:0] ctr[3];
    logic signed [63:0] e;
    logic [67:0] l2;
    logic [67:0] len;
    logic [67:0] q;
    logic [67:0] mag;
    logic [63:0] ml2;
    logic flip;
    row_word_t w;
    l2 = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 64'(p[i+3]) - 64'(p[i]);
      mag = (d[i] < 0) ? 68'(-d[i]) : 68'(d[i]);
      l2 += mag * mag;
      ctr[i] = (64'(p[i]) + 64'(p[i+3])) >>> 1;
    end
    ml2 = 64'(min_length_q) * 64'(min_length_q);
    if (l2 < 68'(ml2) || l2 == 0) begin
      w = '{2'd0, 1'b1, 1'b0, '0, '0, '0, '0, '0};
      expected_rows = {expected_rows, w};
      n_rejects++;
      return;
    end
    len = root_of(l2);
    for (int i = 0; i < 3; i++) begin
      mag = (d[i] < 0) ? 68'(-d[i]) : 68'(d[i]);
      q = ((mag << UF) + (len >> 1)) / len;
      nv[i] = (d[i] < 0) ? -$signed(64'(q)) : $signed(64'(q));
    end
    if (((nv[0] < 0) ? -nv[0] : nv[0]) > 64'(sign_eps_q)) flip = nv[0] < 0;
    else if (((nv[1] < 0) ? -nv[1] : nv[1]) > 64'(sign_eps_q)) flip = nv[1] < 0;
    else flip = nv[2] < 0;
    if (flip) for (int i = 0; i < 3; i++) nv[i] = -nv[i];
    for (int i = 0; i < 3; i++) begin
      logic [31:0] cols[3];
      for (int j = 0; j < 3; j++) begin
        e = -twice_round(nv[i], nv[j]);
        if (i == j) e += 64'sd1 << UF;
        cols[j] = e[31:0];
      end
      w = '{i[1:0], i == 2, 1'b1, cols[0], cols[1], cols[2], nv[i][31:0], ctr[i][31:0]};
      expected_rows = {expected_rows, w};
    end
  endtask

  function automatic bit idle_now(bit burst);
    return !burst && ($urandom_range(99) < 17);
  endfunction

  // entered and left at a falling edge; valid stays up for a word that follows at once
  task automatic send_pair(logic signed [31:0] p[6]);
    while (idle_now(in_burst)) begin
      pair_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    pair_in.first_x <= p[0];
    pair_in.first_y <= p[1];
    pair_in.first_z <= p[2];
    pair_in.second_x <= p[3];
    pair_in.second_y <= p[4];
    pair_in.second_z <= p[5];
    pair_in.valid <= 1'b1;
    do @(posedge clk_i); while (!pair_in.ready);
    predict_reflection(p);
    n_pairs++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(ppr_cfg_e idx, logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MIN_LENGTH) min_length_q = val;
    else sign_eps_q = val;
  endtask

  task automatic drain();
    pair_in.valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  always @(negedge clk_i) row_out.ready <= !idle_now(out_burst);

  always @(posedge clk_i) begin
    if (rst_ni && row_out.valid && row_out.ready) begin
      row_word_t x;
      n_rows++;
      if (expected_rows.size() == 0) begin
        $error("row word with nothing expected");
        n_errors++;
      end else begin
        x = expected_rows.pop_front();
        if (row_out.row_index !== x.row_index) begin
          $error("row_index exp %0d got %0d", x.row_index, row_out.row_index); n_errors++;
        end
        if (row_out.is_last !== x.is_last) begin
          $error("is_last exp %0d got %0d", x.is_last, row_out.is_last); n_errors++;
        end
        if (row_out.valid_res !== x.valid_res) begin
          $error("valid_res exp %0d got %0d", x.valid_res, row_out.valid_res); n_errors++;
        end
        if (row_out.mat_col0 !== x.col0) begin
          $error("mat_col0 exp %h got %h", x.col0, row_out.mat_col0); n_errors++;
        end
        if (row_out.mat_col1 !== x.col1) begin
          $error("mat_col1 exp %h got %h", x.col1, row_out.mat_col1); n_errors++;
        end
        if (row_out.mat_col2 !== x.col2) begin
          $error("mat_col2 exp %h got %h", x.col2, row_out.mat_col2); n_errors++;
        end
        if (row_out.normal_part !== x.normal) begin
          $error("normal_part exp %h got %h", x.normal, row_out.normal_part); n_errors++;
        end
        if (row_out.center_part !== x.center) begin
          $error("center_part exp %h got %h", x.center, row_out.center_part); n_errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $signed(32'($urandom_range(4096))) - 2048;
      2: return {{8{$urandom_range(1) == 1}}, 24'($urandom())};
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] p[6];
    p = '{0, 0, 0, 0, 0, 0};                      send_pair(p); // coincident
    p = '{0, 0, 0, 1, 0, 0};                      send_pair(p);
    p = '{0, 0, 0, -65536, 0, 0};                 send_pair(p);
    p = '{0, 0, 0, 0, -65536, 0};                 send_pair(p);
    p = '{0, 0, 0, 0, 0, -65536};                 send_pair(p);
    p = '{0, 0, 65536, 0, 0, 0};                  send_pair(p);
    p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          32'sh80000000, 32'sh80000000, 32'sh80000000}; send_pair(p);
    p = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000,
          32'sh7fffffff, 32'sh80000000, 32'sh7fffffff}; send_pair(p);
    p = '{-3, -5, 7, 65536, -65536, 131072};      send_pair(p);
    p = '{1, 1, 1, 2, 2, 2};                       send_pair(p);
    p = '{-1, -1, -1, -2, -2, -2};                 send_pair(p);
    p = '{100, 0, 0, 100, 1, -1000000};            send_pair(p); // tiny x and y
    drain();
  endtask

  task automatic test_config_extremes();
    logic signed [31:0] p[6];
    write_reg(CFG_MIN_LENGTH, 31'd0);
    write_reg(CFG_SIGN_EPSILON, 31'd0);
    p = '{0, 0, 0, 0, 0, 0};              send_pair(p);
    p = '{5, 0, 0, 5, -1, 0};             send_pair(p);
    p = '{0, 0, 0, 0, 0, -1};             send_pair(p);
    drain();
    write_reg(CFG_MIN_LENGTH, 31'h7fffffff);
    write_reg(CFG_SIGN_EPSILON, 31'h7fffffff); // beyond unit: z decides
    p = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}; send_pair(p);
    p = '{32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0}; send_pair(p);
    p = '{0, 0, 0, -65536, -65536, -65536};          send_pair(p);
    drain();
    write_reg(CFG_MIN_LENGTH, 31'd65536);
    write_reg(CFG_SIGN_EPSILON, 31'h40000000);
    p = '{0, 0, 0, 65535, 0, 0};          send_pair(p);
    p = '{0, 0, 0, 65536, 0, 0};          send_pair(p);
    p = '{0, 0, 0, 0, 0, -65536};         send_pair(p);
    p = '{0, 0, 0, 1000000, -1000000, 0}; send_pair(p);
    drain();
  endtask

  task automatic test_random();
    logic signed [31:0] p[6];
    logic [30:0] lens[4] = '{31'd1, 31'd0, 31'd40000, 31'($urandom())};
    logic [30:0] epss[4] = '{31'd128, 31'd0, 31'h3fffffff, 31'h40000000};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_MIN_LENGTH, lens[ph]);
      write_reg(CFG_SIGN_EPSILON, epss[ph] ^ 31'($urandom_range(255)));
      for (int k = 0; k < 115; k++) begin
        in_burst = (k >= 40 && k < 70);
        out_burst = in_burst;
        for (int i = 0; i < 6; i++) p[i] = rand_coord();
        if ($urandom_range(9) == 0) for (int i = 0; i < 3; i++)
          p[i+3] = p[i] + $signed(32'($urandom_range(6))) - 3;
        send_pair(p);
      end
      in_burst = 1'b0;
      out_burst = 1'b0;
      drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_directed();
    test_config_extremes();
    test_random();
    $display("%0d pairs sent, %0d row words checked, %0d pairs rejected as too close",
             n_pairs, n_rows, n_rejects);
    if (n_errors == 0 && expected_rows.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
